>>> hdl/bcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box-Cox second derivative package
// Shared constants and codes of the Box-Cox second derivative pipeline.
// ----------------------------------------------------------------------------
package bcsd_pkg;

   // ln(2) in Q30.
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   // Below this magnitude of lambda*ln(x) in Q40 the series form is used.
   localparam logic signed [49:0] SERIES_LIMIT_Q40 = 50'sd10995;

   // Number of squaring steps of the log2 unit (fraction bits of log2 x).
   localparam int unsigned LOG_STEPS = 28;

   // Number of Taylor terms of the 2^f unit.
   localparam int unsigned EXP_TERMS = 16;

   // Latency of the divider and of the power unit, which run side by side.
   localparam int unsigned ARITH_LATENCY = 33;

   localparam logic [15:0] LAMBDA_RESET = 16'h1000;
   localparam logic [31:0] SHIFT_RESET  = 32'h0000_0000;

   // Register indexes of the configuration port.
   localparam logic CSR_LAMBDA = 1'b0;
   localparam logic CSR_SHIFT  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOT_POS = 2'd1,
      STATUS_SAT     = 2'd2
   } status_type;

endpackage
`default_nettype wire

>>> hdl/bcsd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Series quotient divider
// Rounded quotient (num * 256 + den / 2) / den, one quotient bit per stage,
// with an early flag for quotients that do not fit in 32 bits.
// ----------------------------------------------------------------------------
module bcsd_div (
   input  logic        clock,
   input  logic        enable,
   input  logic [50:0] numer_in,
   input  logic [63:0] denom_in,
   output logic [31:0] quotient_out,
   output logic        overflow_out
);

   localparam int unsigned QBITS = 32;

   logic [63:0]      dividend_in;
   logic [63:0]      rem_ff   [QBITS];
   logic [63:0]      den_ff   [QBITS];
   logic [QBITS-1:0] quo_ff   [QBITS+1];
   logic             big_ff   [QBITS+1];

   assign dividend_in = 64'({numer_in, 8'h00}) + (denom_in >> 1);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= dividend_in;
         den_ff[0] <= denom_in;
         quo_ff[0] <= '0;
         big_ff[0] <= {32'h0, dividend_in} >= {denom_in, 32'h0};
      end
   end

   for (genvar j = 1; j <= QBITS; j++) begin : gen_step
      localparam int unsigned BIT = QBITS - j;
      logic [95:0] trial;
      logic        take;

      assign trial = {32'h0, den_ff[j-1]} << BIT;
      assign take  = {32'h0, rem_ff[j-1]} >= trial;

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[j] <= quo_ff[j-1] | (QBITS'(take) << BIT);
            big_ff[j] <= big_ff[j-1];
         end
      end

      if (j < QBITS) begin : gen_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j] <= take ? (rem_ff[j-1] - trial[63:0]) : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quotient_out = quo_ff[QBITS];
   assign overflow_out = big_ff[QBITS];

endmodule
`default_nettype wire

>>> hdl/bcsd_exp2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractional power of two
// Computes scale * 2^f for f in [0,1) Q30 through a truncated Taylor series of
// exp(f*ln2), one multiply stage and one constant-divide stage per term after the first.
// ----------------------------------------------------------------------------
module bcsd_exp2 (
   input  logic        clock,
   input  logic        enable,
   input  logic [29:0] frac_in,
   input  logic [15:0] scale_in,
   output logic [46:0] product_out
);

   localparam int unsigned TERMS = bcsd_pkg::EXP_TERMS;

   logic [59:0] z_prod;
   logic [29:0] z_ff    [TERMS];
   logic [30:0] t_ff    [TERMS];
   logic [30:0] sum_ff  [TERMS+1];
   logic [29:0] mz_ff   [2:TERMS];
   logic [29:0] mt_ff   [2:TERMS];
   logic [30:0] msum_ff [2:TERMS];
   logic [46:0] product_ff;

   assign z_prod = 60'(frac_in) * 60'(bcsd_pkg::LN2_Q30);

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff[0]   <= z_prod[59:30];
         t_ff[0]   <= 31'h4000_0000;
         sum_ff[0] <= 31'h4000_0000;
      end
   end

   // The first term divides by one and needs a single stage.
   logic [60:0] first_prod;
   assign first_prod = 61'(t_ff[0]) * 61'(z_ff[0]);

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff[1]   <= z_ff[0];
         t_ff[1]   <= 31'(first_prod >> 30);
         sum_ff[1] <= sum_ff[0] + 31'(first_prod >> 30);
      end
   end

   for (genvar n = 2; n <= TERMS; n++) begin : gen_term
      // Reciprocal of n scaled by 2^34, rounded up: exact floor for 30-bit values.
      localparam logic [33:0] RECIP = 34'(((64'd1 << 34) + 64'(n) - 64'd1) / 64'(n));
      logic [60:0] mul_prod;
      logic [63:0] div_prod;

      assign mul_prod = 61'(t_ff[n-1]) * 61'(z_ff[n-1]);
      assign div_prod = 64'(mt_ff[n]) * 64'(RECIP);

      always_ff @(posedge clock) begin
         if (enable) begin
            mt_ff[n]   <= 30'(mul_prod >> 30);
            mz_ff[n]   <= z_ff[n-1];
            msum_ff[n] <= sum_ff[n-1];
            sum_ff[n]  <= msum_ff[n] + 31'(div_prod >> 34);
         end
      end

      if (n < TERMS) begin : gen_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               t_ff[n] <= 31'(div_prod >> 34);
               z_ff[n] <= mz_ff[n];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= 47'(scale_in) * 47'(sum_ff[TERMS]);
      end
   end

   assign product_out = product_ff;

endmodule
`default_nettype wire

>>> hdl/box_cox_second_derivative_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box-Cox second derivative unit
// Returns (lambda-1)*x^(lambda-2) for x = sample + shift in Q16.16, or the
// series form near lambda*ln(x) = 0, with error and saturation status.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    req_sample_value (Q16.16)
//   rsp      out        rsp_valid/stall    rsp_second_derivative, status_code
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// One item enters per cycle unless the pipeline holds; each passes from acceptance
// to the output register through the input, normalize, 28 log2 squaring stages,
// 3 setup stages, 33 stages of the divider and power unit side by side, output.
// The whole pipeline advances together: it holds while the output register
// is full and stalled. Reset is synchronous; it empties the pipeline and
// sets lambda to 1.0 and the shift to 0.
// ----------------------------------------------------------------------------
module box_cox_second_derivative_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_second_derivative,
   output logic [1:0]         rsp_status_code,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam int unsigned STEPS = bcsd_pkg::LOG_STEPS;
   localparam int unsigned LAT   = bcsd_pkg::ARITH_LATENCY;

   typedef struct packed {
      logic        bad;
      logic [4:0]  msb;
      logic [31:0] u;
   } log_side_type;

   typedef struct packed {
      logic              bad;
      logic              series;
      logic              q_neg;
      logic signed [9:0] k;
   } arith_side_type;

   // Configuration registers.
   logic signed [15:0] lambda_ff;
   logic signed [31:0] shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= bcsd_pkg::LAMBDA_RESET;
         shift_ff  <= bcsd_pkg::SHIFT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bcsd_pkg::CSR_LAMBDA: lambda_ff <= csr_write_data[15:0];
            bcsd_pkg::CSR_SHIFT:  shift_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;

   assign en        = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~en;

   // Stage A: shifted sample.
   logic signed [32:0] x_in;
   logic               a_valid_ff;
   logic               a_bad_ff;
   logic [31:0]        a_u_ff;

   assign x_in = 33'(req_sample_value) + 33'(shift_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_bad_ff <= x_in[32] | (x_in == '0);
         a_u_ff   <= x_in[31:0];
      end
   end

   // Stage B: leading one and Q30 mantissa.
   logic [4:0]   msb_pos;
   logic [30:0]  norm_in;
   logic [30:0]  lg_m_ff     [STEPS+1];
   logic [27:0]  lg_frac_ff  [STEPS+1];
   logic         lg_valid_ff [STEPS+1];
   log_side_type lg_side_ff  [STEPS+1];

   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (a_u_ff[i]) begin
            msb_pos = 5'(i);
         end
      end
      if (msb_pos == 5'd31) begin
         norm_in = a_u_ff[31:1];
      end else begin
         norm_in = 31'(a_u_ff << (5'd30 - msb_pos));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_valid_ff[0] <= 1'b0;
      end else if (en) begin
         lg_valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lg_m_ff[0]    <= norm_in;
         lg_frac_ff[0] <= '0;
         lg_side_ff[0] <= '{bad: a_bad_ff, msb: msb_pos, u: a_u_ff};
      end
   end

   // log2 fraction bits: square the mantissa, a carry past 2.0 is the next bit.
   for (genvar j = 1; j <= STEPS; j++) begin : gen_log
      logic [61:0] sq;
      logic [31:0] sq_hi;

      assign sq    = 62'(lg_m_ff[j-1]) * 62'(lg_m_ff[j-1]);
      assign sq_hi = sq[61:30];

      always_ff @(posedge clock) begin
         if (reset) begin
            lg_valid_ff[j] <= 1'b0;
         end else if (en) begin
            lg_valid_ff[j] <= lg_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lg_m_ff[j]    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
            lg_frac_ff[j] <= {lg_frac_ff[j-1][26:0], sq_hi[31]};
            lg_side_ff[j] <= lg_side_ff[j-1];
         end
      end
   end

   // Stage C: log2 x in Q28 and ln x rounded to Q28.
   logic signed [32:0] g_in;
   logic [32:0]        g_mag;
   logic [62:0]        ln_prod;
   logic [32:0]        ln_mag;
   logic signed [33:0] lnx_in;
   logic               c_valid_ff;
   logic               c_bad_ff;
   logic [31:0]        c_u_ff;
   logic signed [32:0] c_g_ff;
   logic signed [33:0] c_lnx_ff;

   assign g_in    = {5'(lg_side_ff[STEPS].msb - 5'd16), lg_frac_ff[STEPS]};
   assign g_mag   = g_in[32] ? (~g_in + 33'd1) : g_in;
   assign ln_prod = 63'(g_mag) * 63'(bcsd_pkg::LN2_Q30) + (63'd1 << 29);
   assign ln_mag  = ln_prod[62:30];
   assign lnx_in  = g_in[32] ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= lg_valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_bad_ff <= lg_side_ff[STEPS].bad;
         c_u_ff   <= lg_side_ff[STEPS].u;
         c_g_ff   <= g_in;
         c_lnx_ff <= lnx_in;
      end
   end

   // Stage D: lambda*ln x and the exponent (lambda-2)*log2 x, both Q40.
   logic signed [16:0] lam_m2;
   logic signed [49:0] prod_in;
   logic signed [49:0] expo_in;
   logic               d_valid_ff;
   logic               d_bad_ff;
   logic [31:0]        d_u_ff;
   logic signed [49:0] d_prod_ff;
   logic signed [49:0] d_expo_ff;

   assign lam_m2  = 17'(lambda_ff) - 17'sd8192;
   assign prod_in = 50'(lambda_ff) * 50'(c_lnx_ff);
   assign expo_in = 50'(lam_m2) * 50'(c_g_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_bad_ff  <= c_bad_ff;
         d_u_ff    <= c_u_ff;
         d_prod_ff <= prod_in;
         d_expo_ff <= expo_in;
      end
   end

   // Stage E: series numerator, x^2, and the exponent split into k and f.
   logic signed [51:0] nq_in;
   logic [50:0]        nm_in;
   logic               e_valid_ff;
   logic [50:0]        e_nm_ff;
   logic [63:0]        e_x2_ff;
   logic [29:0]        e_frac_ff;
   arith_side_type     e_side_ff;

   assign nq_in = 52'sh100_0000_0000 - (52'(lambda_ff) <<< 28) + 52'(d_prod_ff);
   assign nm_in = nq_in[51] ? 51'(-nq_in) : 51'(nq_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_nm_ff   <= nm_in;
         e_x2_ff   <= 64'(d_u_ff) * 64'(d_u_ff);
         e_frac_ff <= d_expo_ff[39:10];
         e_side_ff <= '{bad:    d_bad_ff,
                        series: (d_prod_ff <= bcsd_pkg::SERIES_LIMIT_Q40) &&
                                (d_prod_ff >= -bcsd_pkg::SERIES_LIMIT_Q40),
                        q_neg:  ~nq_in[51] & (nq_in != '0),
                        k:      d_expo_ff[49:40]};
      end
   end

   // Divider and power unit, with the side fields delayed alongside.
   logic signed [16:0] lam_m1;
   logic [15:0]        coef_mag;
   logic               coef_neg;
   logic [31:0]        div_q;
   logic               div_big;
   logic [46:0]        exp_product;

   assign lam_m1   = 17'(lambda_ff) - 17'sd4096;
   assign coef_neg = lam_m1[16];
   assign coef_mag = coef_neg ? 16'(-lam_m1) : 16'(lam_m1);

   bcsd_div u_div (
      .clock        (clock),
      .enable       (en),
      .numer_in     (e_nm_ff),
      .denom_in     (e_x2_ff),
      .quotient_out (div_q),
      .overflow_out (div_big)
   );

   bcsd_exp2 u_exp2 (
      .clock       (clock),
      .enable      (en),
      .frac_in     (e_frac_ff),
      .scale_in    (coef_mag),
      .product_out (exp_product)
   );

   logic           sd_valid_ff [LAT];
   arith_side_type sd_side_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_valid_ff[0] <= 1'b0;
      end else if (en) begin
         sd_valid_ff[0] <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_side_ff[0] <= e_side_ff;
      end
   end

   for (genvar d = 1; d < LAT; d++) begin : gen_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            sd_valid_ff[d] <= 1'b0;
         end else if (en) begin
            sd_valid_ff[d] <= sd_valid_ff[d-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sd_side_ff[d] <= sd_side_ff[d-1];
         end
      end
   end

   // Output stage: scale by 2^(k-26), round, pick the path and saturate.
   logic signed [10:0]   s_val;
   logic [10:0]          r_val;
   logic [48:0]          round_sum;
   logic [47:0]          main_mag;
   logic                 main_over;
   logic [47:0]          sel_mag;
   logic                 sel_over;
   logic                 sel_neg;
   logic [47:0]          lim;
   logic signed [31:0]   value_in;
   bcsd_pkg::status_type status_in;
   logic signed [31:0]   rsp_value_ff;
   bcsd_pkg::status_type rsp_status_ff;

   always_comb begin
      s_val     = 11'(sd_side_ff[LAT-1].k) - 11'sd26;
      r_val     = 11'(-s_val);
      round_sum = '0;
      main_mag  = '0;
      main_over = 1'b0;
      if (exp_product != '0) begin
         if (s_val > 11'sd0) begin
            if (s_val >= 11'sd32) begin
               main_over = 1'b1;
            end else if (48'(exp_product) > (48'h8000_0000 >> s_val[4:0])) begin
               main_over = 1'b1;
            end else begin
               main_mag = 48'(exp_product) << s_val[4:0];
            end
         end else if (s_val == 11'sd0) begin
            main_mag = 48'(exp_product);
         end else if (r_val < 11'd48) begin
            round_sum = 49'(exp_product) + (49'd1 << (r_val[5:0] - 6'd1));
            main_mag  = 48'(round_sum >> r_val[5:0]);
         end
      end

      if (sd_side_ff[LAT-1].series) begin
         sel_mag  = 48'(div_q);
         sel_over = div_big;
         sel_neg  = sd_side_ff[LAT-1].q_neg;
      end else begin
         sel_mag  = main_mag;
         sel_over = main_over;
         sel_neg  = coef_neg;
      end
      lim = sel_neg ? 48'h8000_0000 : 48'h7FFF_FFFF;

      if (sd_side_ff[LAT-1].bad) begin
         value_in  = '0;
         status_in = bcsd_pkg::STATUS_NOT_POS;
      end else if (sel_over || (sel_mag > lim)) begin
         value_in  = sel_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         status_in = bcsd_pkg::STATUS_SAT;
      end else begin
         value_in  = sel_neg ? -$signed(sel_mag[31:0]) : $signed(sel_mag[31:0]);
         status_in = bcsd_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sd_valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff  <= value_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_second_derivative = rsp_value_ff;
   assign rsp_status_code       = rsp_status_ff;

   // A saturated item always carries one of the two clamp values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == bcsd_pkg::STATUS_SAT) |->
         (rsp_value_ff == 32'sh7FFF_FFFF) || (rsp_value_ff == 32'sh8000_0000))
      else $error("saturated item without a clamp value");

   // A sample that is not positive after the shift gives a zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == bcsd_pkg::STATUS_NOT_POS) |->
         (rsp_value_ff == '0))
      else $error("error item with a nonzero result");

   // An accepted item is in the first stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> a_valid_ff)
      else $error("accepted item lost at the input stage");

   // The pipeline comes out of reset empty.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid_ff && !sd_valid_ff[LAT-1])
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
